/* hw/rtl/trpq_pkg.sv */
// shared types, codes and compare function of the timed release priority queue
package trpq_pkg;

  localparam int TIME_W = 63;
  localparam int SEQ_W  = 64;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_SCHED_AT    = 3'd0,
    OP_SCHED_AFTER = 3'd1,
    OP_TAKE        = 3'd2,
    OP_SHUTDOWN    = 3'd3,
    OP_TICK        = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STOPPED   = 3'd1,
    ST_SEQ_EXH   = 3'd2,
    ST_DUE_OVF   = 3'd3,
    ST_Q_FULL    = 3'd4,
    ST_HO_EMPTY  = 3'd5
  } status_t;

  // configuration register indexes
  typedef enum logic {
    REG_HANDOFF_CAP = 1'b0,
    REG_SEQ_START   = 1'b1
  } reg_idx_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP_RD,
    S_UP_CMP,
    S_TAKE,
    S_DRAIN,
    S_DRAIN_CHK,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_t;

  // heap order: earlier due time first, then lower sequence
  function automatic logic earlier(input logic [TIME_W-1:0] due_a,
                                   input logic [SEQ_W-1:0]  seq_a,
                                   input logic [TIME_W-1:0] due_b,
                                   input logic [SEQ_W-1:0]  seq_b);
    logic res;
    res = (due_a < due_b) || ((due_a == due_b) && (seq_a < seq_b));
    return res;
  endfunction

endpackage

/* hw/rtl/timed_release_priority_queue.sv */
// top level of the timed release priority queue
// Usage: each input transfer on s_axis carries an operation (tuser) and the
// current time, a due time or delay and a payload (tdata). Every input item
// gives exactly one result on m_axis: a status, the released payload, the
// heap and handoff fill levels and the running flag after the drain.
// Configuration is written on cfg_* (index 0 handoff capacity, index 1
// sequence start, which also reloads the next sequence) while idle.
// Items are handled one at a time: each passes the exec, drain and result
// states, a take adds a handoff read, a schedule adds a sift-up from the new
// leaf toward the root, and each due entry moved into the handoff fifo adds a
// root check and a sift-down of the last entry from the root. The time-ordered
// entries live in one heap memory with one write and two registered read ports,
// which pace each sift step.
// Reset clears fill counts, the stop flag and the sequence; memory contents
// stay undefined and are never read before being written.
// The result sits in an output register; the next input item is taken while
// it waits, and the block holds before its own result if the receiver still
// stalls the previous one.
module timed_release_priority_queue #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int HANDOFF_DEPTH = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int IN_W  = ((2*63 + PAYLOAD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 + PAYLOAD_WIDTH + $clog2(QUEUE_DEPTH+1)
                           + $clog2(HANDOFF_DEPTH+1) + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // current_time, time_value, payload
  input  logic [2:0]       s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status, released_payload, scheduled_count, handoff_count, running
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             m_axis_tuser,  // released_valid
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [63:0]      cfg_data
);
  import trpq_pkg::*;

  localparam int IW  = $clog2(QUEUE_DEPTH);
  localparam int SW  = $clog2(QUEUE_DEPTH + 1);
  localparam int HCW = $clog2(HANDOFF_DEPTH + 1);
  localparam int EW  = TIME_W + SEQ_W + PAYLOAD_WIDTH;
  localparam int PAY_LO  = 2 * TIME_W;

  state_t state, state_next;

  // latched input item
  logic [2:0]               op_r;
  logic [TIME_W-1:0]        now_r;
  logic [TIME_W-1:0]        tv_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;

  // control state
  logic [4:0]       cap;
  logic [SEQ_W-1:0] next_seq;
  logic             stopped;
  logic [SW-1:0]    heap_size;
  logic [IW-1:0]    hole;

  // working entries and result
  logic [EW-1:0]            ent;
  logic [2:0]               status_r;
  logic [PAYLOAD_WIDTH-1:0] rel_r;
  logic                     rel_valid_r;

  // heap memory
  logic [EW-1:0] heap_mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_a, rd_b;
  logic [IW-1:0] addr_a, addr_b, waddr;
  logic [EW-1:0] wdata;
  logic          we;

  // handoff fifo
  logic                     ho_push, ho_pop, ho_full;
  logic [PAYLOAD_WIDTH-1:0] ho_data;
  logic [PAYLOAD_WIDTH-1:0] ho_rd;
  logic [HCW-1:0]           ho_count;

  // decisions
  logic [TIME_W:0]  due_sum;
  logic             due_ovf;
  logic [2:0]       sched_status;
  logic [IW-1:0]    parent;
  logic [IW:0]      lidx;
  logic [IW+1:0]    ridx;
  logic             lvalid, rvalid, pick_l, pick_r, up_move, root_due;
  logic [EW-1:0]    best;
  logic             out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // schedule checks
  always_comb begin
    due_sum = {1'b0, now_r} + {1'b0, tv_r};
    due_ovf = (op_r == OP_SCHED_AFTER) && due_sum[TIME_W];
    if (due_ovf) begin
      sched_status = ST_DUE_OVF;
    end else if (stopped) begin
      sched_status = ST_STOPPED;
    end else if (next_seq == '1) begin
      sched_status = ST_SEQ_EXH;
    end else if (heap_size >= SW'(QUEUE_DEPTH)) begin
      sched_status = ST_Q_FULL;
    end else begin
      sched_status = ST_OK;
    end
  end

  // sift compares
  always_comb begin
    parent   = IW'((hole - IW'(1)) >> 1);
    lidx     = {hole, 1'b1};
    ridx     = (IW+2)'(lidx) + (IW+2)'(1);
    lvalid   = (IW+2)'(lidx) < (IW+2)'(heap_size);
    rvalid   = ridx < (IW+2)'(heap_size);
    up_move  = earlier(ent[TIME_W-1:0], ent[TIME_W+SEQ_W-1:TIME_W],
                       rd_a[TIME_W-1:0], rd_a[TIME_W+SEQ_W-1:TIME_W]);
    pick_l   = lvalid && earlier(rd_a[TIME_W-1:0], rd_a[TIME_W+SEQ_W-1:TIME_W],
                                 ent[TIME_W-1:0], ent[TIME_W+SEQ_W-1:TIME_W]);
    best     = pick_l ? rd_a : ent;
    pick_r   = rvalid && earlier(rd_b[TIME_W-1:0], rd_b[TIME_W+SEQ_W-1:TIME_W],
                                 best[TIME_W-1:0], best[TIME_W+SEQ_W-1:TIME_W]);
    root_due = rd_a[TIME_W-1:0] <= now_r;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (op_r)
          OP_SCHED_AT, OP_SCHED_AFTER: begin
            state_next = (sched_status == ST_OK) ? S_UP_RD : S_DRAIN;
          end
          OP_TAKE: begin
            state_next = (ho_count != '0) ? S_TAKE : S_DRAIN;
          end
          default: state_next = S_DRAIN;
        endcase
      end
      S_UP_RD:   state_next = (hole == '0) ? S_DRAIN : S_UP_CMP;
      S_UP_CMP:  state_next = up_move ? S_UP_RD : S_DRAIN;
      S_TAKE:    state_next = S_DRAIN;
      S_DRAIN: begin
        if (stopped || heap_size == '0 || ho_full) state_next = S_RESP;
        else state_next = S_DRAIN_CHK;
      end
      S_DRAIN_CHK: begin
        if (!root_due) state_next = S_RESP;
        else if (heap_size == SW'(1)) state_next = S_DRAIN;
        else state_next = S_DN_LOAD;
      end
      S_DN_LOAD: state_next = S_DN_RD;
      S_DN_RD:   state_next = S_DN_CMP;
      S_DN_CMP:  state_next = (pick_l || pick_r) ? S_DN_RD : S_DRAIN;
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory and fifo controls
  always_comb begin
    addr_a  = '0;
    addr_b  = '0;
    we      = 1'b0;
    waddr   = hole;
    wdata   = ent;
    ho_push = 1'b0;
    ho_pop  = 1'b0;
    ho_data = rd_a[EW-1:PAY_LO+1];
    unique case (state)
      S_EXEC: begin
        ho_pop = (op_r == OP_TAKE) && (ho_count != '0);
      end
      S_UP_RD: begin
        addr_a = parent;
        we     = (hole == '0);
      end
      S_UP_CMP: begin
        we    = 1'b1;
        wdata = up_move ? rd_a : ent;
      end
      S_DRAIN_CHK: begin
        ho_push = root_due;
        addr_a  = IW'(heap_size - SW'(1));
      end
      S_DN_RD: begin
        addr_a = IW'(lidx);
        addr_b = IW'(ridx);
      end
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = pick_r ? rd_b : (pick_l ? rd_a : ent);
      end
      default: begin
        addr_a = '0;
      end
    endcase
  end

  // heap memory with registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rd_a <= heap_mem[addr_a];
    rd_b <= heap_mem[addr_b];
  end

  // item latch and working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      op_r  <= s_axis_tuser;
      now_r <= s_axis_tdata[TIME_W-1:0];
      tv_r  <= s_axis_tdata[2*TIME_W-1:TIME_W];
      pay_r <= s_axis_tdata[PAY_LO+PAYLOAD_WIDTH-1:PAY_LO];
    end
    unique case (state)
      S_EXEC: begin
        hole  <= IW'(heap_size);
        ent   <= {pay_r, next_seq,
                  (op_r == OP_SCHED_AFTER) ? due_sum[TIME_W-1:0] : tv_r};
        rel_r <= '0;
      end
      S_UP_CMP: begin
        if (up_move) hole <= parent;
      end
      S_TAKE: begin
        rel_r <= ho_rd;
      end
      S_DN_LOAD: begin
        ent  <= rd_a;
        hole <= '0;
      end
      S_DN_CMP: begin
        if (pick_r) hole <= IW'(ridx);
        else if (pick_l) hole <= IW'(lidx);
      end
      default: begin
        hole <= hole;
      end
    endcase
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cap         <= 5'd16;
      next_seq    <= '0;
      stopped     <= 1'b0;
      heap_size   <= '0;
      status_r    <= ST_OK;
      rel_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_HANDOFF_CAP: cap      <= cfg_data[4:0];
          REG_SEQ_START:   next_seq <= cfg_data;
          default:         cap      <= cap;
        endcase
      end
      unique case (state)
        S_EXEC: begin
          rel_valid_r <= 1'b0;
          status_r    <= ST_OK;
          case (op_r)
            OP_SCHED_AT, OP_SCHED_AFTER: begin
              status_r <= sched_status;
              if (sched_status == ST_OK) begin
                heap_size <= heap_size + SW'(1);
                next_seq  <= next_seq + SEQ_W'(1);
              end
            end
            OP_TAKE: begin
              if (ho_count == '0) status_r <= ST_HO_EMPTY;
            end
            OP_SHUTDOWN: stopped <= 1'b1;
            default: stopped <= stopped;
          endcase
        end
        S_TAKE: rel_valid_r <= 1'b1;
        S_DRAIN_CHK: begin
          if (root_due) heap_size <= heap_size - SW'(1);
        end
        default: stopped <= stopped;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      m_axis_tdata <= OUT_W'({!stopped, ho_count, heap_size, rel_r, status_r});
      m_axis_tuser <= rel_valid_r;
    end
  end

  trpq_handoff #(
    .DEPTH (HANDOFF_DEPTH),
    .DW    (PAYLOAD_WIDTH)
  ) u_handoff (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .push      (ho_push),
    .push_data (ho_data),
    .pop       (ho_pop),
    .pop_data  (ho_rd),
    .count     (ho_count),
    .full      (ho_full)
  );

endmodule

/* hw/rtl/trpq_handoff.sv */
// handoff fifo of due messages with a programmable fill limit
module trpq_handoff #(
  parameter int DEPTH = 16,
  parameter int DW    = 32,
  localparam int FW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [4:0]    cap,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic [CW-1:0] count,
  output logic          full
);

  localparam int MW = (CW > 5) ? CW : 5;

  logic [DW-1:0] store [DEPTH];
  logic [FW-1:0] head;
  logic [FW-1:0] tail;
  logic [CW:0]   tail_sum;
  logic [CW:0]   head_inc;
  logic [MW-1:0] eff_cap;

  // capacity zero acts as one, above depth acts as depth
  always_comb begin
    eff_cap = MW'(cap);
    if (cap == 5'd0) begin
      eff_cap = MW'(1);
    end else if (MW'(cap) > MW'(DEPTH)) begin
      eff_cap = MW'(DEPTH);
    end
  end

  assign full = MW'(count) >= eff_cap;

  // circular write slot and head advance
  always_comb begin
    tail_sum = (CW+1)'(head) + (CW+1)'(count);
    if (tail_sum >= (CW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(DEPTH);
    end
    tail = FW'(tail_sum);
    head_inc = (CW+1)'(head) + (CW+1)'(1);
    if (head_inc >= (CW+1)'(DEPTH)) begin
      head_inc = '0;
    end
  end

  // storage with registered read
  always_ff @(posedge clk) begin
    if (push) begin
      store[tail] <= push_data;
    end
    if (pop) begin
      pop_data <= store[head];
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (push) begin
      count <= count + CW'(1);
    end else if (pop) begin
      head  <= FW'(head_inc);
      count <= count - CW'(1);
    end
  end

endmodule

/* hw/rtl/trpq_checker.sv */
// port-level checks of the timed release priority queue and their binding
module trpq_checker #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int HANDOFF_DEPTH = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int OUT_W = ((3 + PAYLOAD_WIDTH + $clog2(QUEUE_DEPTH+1)
                           + $clog2(HANDOFF_DEPTH+1) + 1 + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);
  import trpq_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // a released message always comes with ok status
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] == ST_OK)
    else $error("release with error status");

  // one item at a time: input not ready right after a transfer in
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

endmodule

bind timed_release_priority_queue trpq_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .HANDOFF_DEPTH (HANDOFF_DEPTH),
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_trpq_checker (.*);
